@@ design/imk_pkg.sv @@
`timescale 1ns / 1ps

package imk_pkg;

    localparam int TONE_W = 16;
    localparam int UNIT_W = 16;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] DAH_UNITS = CNT_W'(3);
    localparam logic [CNT_W-1:0] MODE_A_ELEMENTS = CNT_W'(2);

    localparam logic [1:0] OP_POLL = 2'd0;
    localparam logic [1:0] OP_ENABLE = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;

    localparam logic [1:0] KEY_STRAIGHT = 2'd0;
    localparam logic [1:0] KEY_IAMBIC_A = 2'd1;
    localparam logic [1:0] KEY_IAMBIC_B = 2'd2;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_KEY_MODE = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_TONE_PERIOD = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_UNIT_PERIOD = 4'h8;

    typedef enum logic [3:0] {
        ST_DISABLED = 4'd0,
        ST_IDLE = 4'd1,
        ST_STR_IDLE = 4'd2,
        ST_STR_DOWN = 4'd3,
        ST_IAM_IDLE = 4'd4,
        ST_DIT = 4'd5,
        ST_DAH = 4'd6,
        ST_DIT_GAP = 4'd7,
        ST_DAH_GAP = 4'd8
    } state_t;

    // Packed from the top down; tone_start lands in bit 0.
    typedef struct packed {
        logic pad;
        logic symbol_is_dah;
        logic symbol_valid;
        logic [CNT_W-1:0] gap_units;
        logic gap_valid;
        logic [UNIT_W-1:0] timer_value;
        logic timer_restart;
        logic [TONE_W-1:0] tone_value;
        logic tone_force_off;
        logic tone_stop;
        logic tone_start;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

@@ design/iambic_morse_keyer.sv @@
`timescale 1ns / 1ps

// Morse key controller. Each item on the s_ channel is one poll, enable or
// disable command plus the paddle levels and event bits; every item yields
// exactly one result item on the m_ channel. Items are taken one per clock
// while results drain: the state update and the result are formed in the
// cycle of acceptance and the result sits in a single output register, so
// it appears in the cycle after its item is taken. s_tready stays high while
// that register is empty or being drained, giving a sustained rate of one
// item per cycle. APB byte addresses: 0x0 key_mode, 0x4 tone_period, 0x8 unit_period.
module iambic_morse_keyer
    import imk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // dit_pressed, dah_pressed, unit_tick, dit_latch_set, dah_latch_set, 3'b0
    input  logic [7:0]          s_tdata,
    // op
    input  logic [1:0]          s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // tone_start, tone_stop, tone_force_off, tone_value[15:0], timer_restart,
    // timer_value[15:0], gap_valid, gap_units[7:0], symbol_valid,
    // symbol_is_dah, 1'b0
    output logic [RESULT_W-1:0] m_tdata,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [1:0]        key_mode_reg;
    logic [TONE_W-1:0] tone_period_reg;
    logic [UNIT_W-1:0] unit_period_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  unit_count_reg, unit_count_next;
    logic [CNT_W-1:0]  element_count_reg, element_count_next;
    logic              dit_latched_reg, dit_latched_next;
    logic              dah_latched_reg, dah_latched_next;
    logic              tick_pending_reg, tick_pending_next;

    logic              m_tvalid_reg;
    result_t           m_tdata_reg;
    result_t           res;

    logic              accept;
    logic              cfg_write;
    logic [1:0]        op;
    logic              dit, dah, any;
    logic              tick_eff, dit_l, dah_l;
    logic              iambic;
    logic [CNT_W-1:0]  unit_inc, element_inc;
    logic              dah_done;
    logic              after_dah, dit_keep, dah_keep;
    logic              mode_a_stop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr)
            ADDR_KEY_MODE:    prdata = {30'd0, key_mode_reg};
            ADDR_TONE_PERIOD: prdata = {16'd0, tone_period_reg};
            ADDR_UNIT_PERIOD: prdata = {16'd0, unit_period_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mode_reg    <= KEY_STRAIGHT;
            tone_period_reg <= '0;
            unit_period_reg <= '0;
        end else if (cfg_write) begin
            case (paddr)
                ADDR_KEY_MODE:    key_mode_reg    <= pwdata[1:0];
                ADDR_TONE_PERIOD: tone_period_reg <= pwdata[TONE_W-1:0];
                ADDR_UNIT_PERIOD: unit_period_reg <= pwdata[UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign op  = s_tuser;
    assign dit = s_tdata[0];
    assign dah = s_tdata[1];
    assign any = dit || dah;

    // Event bits apply before the operation.
    assign tick_eff = tick_pending_reg || s_tdata[2];
    assign dit_l    = dit_latched_reg || s_tdata[3];
    assign dah_l    = dah_latched_reg || s_tdata[4];

    assign iambic      = (key_mode_reg == KEY_IAMBIC_A) || (key_mode_reg == KEY_IAMBIC_B);
    assign unit_inc    = sat_inc(unit_count_reg);
    assign element_inc = sat_inc(element_count_reg);
    assign dah_done    = unit_inc >= DAH_UNITS;

    assign after_dah   = (state_reg == ST_DAH_GAP);
    assign dit_keep    = after_dah ? dit_l : 1'b0;
    assign dah_keep    = after_dah ? 1'b0 : dah_l;
    assign mode_a_stop = !any && (key_mode_reg == KEY_IAMBIC_A)
                         && (element_inc >= MODE_A_ELEMENTS);

    always_comb begin
        state_next         = state_reg;
        unit_count_next    = unit_count_reg;
        element_count_next = element_count_reg;
        dit_latched_next   = dit_l;
        dah_latched_next   = dah_l;
        tick_pending_next  = tick_eff;
        case (op)
            OP_ENABLE:  state_next = ST_IDLE;
            OP_DISABLE: state_next = ST_DISABLED;
            OP_POLL: begin
                case (state_reg)
                    ST_IDLE: state_next = iambic ? ST_IAM_IDLE : ST_STR_IDLE;
                    ST_STR_IDLE: if (any) state_next = ST_STR_DOWN;
                    ST_STR_DOWN: if (!any) state_next = ST_IDLE;
                    ST_IAM_IDLE: begin
                        if (tick_eff) begin
                            tick_pending_next = 1'b0;
                            unit_count_next   = unit_inc;
                        end
                        if (any) begin
                            state_next         = dit ? ST_DIT : ST_DAH;
                            tick_pending_next  = 1'b0;
                            unit_count_next    = '0;
                            element_count_next = '0;
                        end
                    end
                    ST_DIT: begin
                        if (tick_eff) begin
                            tick_pending_next = 1'b0;
                            state_next        = ST_DIT_GAP;
                        end
                    end
                    ST_DAH: begin
                        if (tick_eff) begin
                            tick_pending_next = 1'b0;
                            unit_count_next   = unit_inc;
                            if (dah_done) state_next = ST_DAH_GAP;
                        end
                    end
                    ST_DIT_GAP, ST_DAH_GAP: begin
                        if (tick_eff) begin
                            tick_pending_next  = 1'b0;
                            unit_count_next    = '0;
                            element_count_next = element_inc;
                            dit_latched_next   = dit_keep;
                            dah_latched_next   = dah_keep;
                            if (mode_a_stop) begin
                                dit_latched_next = 1'b0;
                                dah_latched_next = 1'b0;
                                state_next       = ST_IDLE;
                            end else if (after_dah && dit_keep) begin
                                state_next = ST_DIT;
                            end else if (dah_keep) begin
                                state_next = ST_DAH;
                            end else if (dit_keep) begin
                                state_next = ST_DIT;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        res = '0;
        case (op)
            OP_ENABLE, OP_DISABLE: res.tone_force_off = 1'b1;
            OP_POLL: begin
                case (state_reg)
                    ST_STR_IDLE: res.tone_start = any;
                    ST_STR_DOWN: res.tone_stop = !any;
                    ST_IAM_IDLE: begin
                        if (any) begin
                            res.gap_valid     = 1'b1;
                            res.gap_units     = tick_eff ? unit_inc : unit_count_reg;
                            res.tone_start    = 1'b1;
                            res.timer_restart = 1'b1;
                        end
                    end
                    ST_DIT: begin
                        res.tone_stop    = tick_eff;
                        res.symbol_valid = tick_eff;
                    end
                    ST_DAH: begin
                        if (tick_eff && dah_done) begin
                            res.tone_stop     = 1'b1;
                            res.symbol_valid  = 1'b1;
                            res.symbol_is_dah = 1'b1;
                        end
                    end
                    ST_DIT_GAP, ST_DAH_GAP: begin
                        res.tone_start = tick_eff
                                         && (state_next == ST_DIT || state_next == ST_DAH);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.tone_value  = res.tone_start ? tone_period_reg : '0;
        res.timer_value = res.timer_restart ? unit_period_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_DISABLED;
            unit_count_reg    <= '0;
            element_count_reg <= '0;
            dit_latched_reg   <= 1'b0;
            dah_latched_reg   <= 1'b0;
            tick_pending_reg  <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                state_reg         <= state_next;
                unit_count_reg    <= unit_count_next;
                element_count_reg <= element_count_next;
                dit_latched_reg   <= dit_latched_next;
                dah_latched_reg   <= dah_latched_next;
                tick_pending_reg  <= tick_pending_next;
            end
            if (s_tready) m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) m_tdata_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ design/imk_checker.sv @@
`timescale 1ns / 1ps

module imk_checker
    import imk_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [RESULT_W-1:0] m_tdata
);

    result_t r;
    assign r = result_t'(m_tdata);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_item_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    a_values_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r.tone_start || r.tone_value == '0)
                     && (r.timer_restart || r.timer_value == '0)
                     && (r.gap_valid || r.gap_units == '0)
                     && (r.symbol_valid || !r.symbol_is_dah))
        else $error("payload value without its flag");

    a_force_off_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.tone_force_off |-> !r.tone_start && !r.tone_stop
                                        && !r.gap_valid && !r.symbol_valid)
        else $error("force off combined with other events");

    a_restart_with_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.timer_restart |-> r.tone_start && r.gap_valid)
        else $error("timer restart outside element start from idle");

endmodule

bind iambic_morse_keyer imk_checker u_imk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/keyer_checker.sv @@
`timescale 1ns / 1ps

module keyer_checker
    import imk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [RESULT_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  outstanding
);

    logic [1:0]       key_mode;
    logic [TONE_W-1:0] tone_period;
    logic [UNIT_W-1:0] unit_period;

    state_t           key_state;
    logic [CNT_W-1:0] unit_cnt;
    logic [CNT_W-1:0] elem_cnt;
    logic             dit_lat;
    logic             dah_lat;
    logic             tick_pend;

    result_t          keyer_outputs[$];
    result_t          got;
    result_t          want;

    function automatic string describe(input result_t r);
        return $sformatf({"start=%b stop=%b off=%b tone=%h restart=%b timer=%h ",
                          "gap=%b/%0d sym=%b/%b pad=%b"},
                         r.tone_start, r.tone_stop, r.tone_force_off, r.tone_value,
                         r.timer_restart, r.timer_value, r.gap_valid, r.gap_units,
                         r.symbol_valid, r.symbol_is_dah, r.pad);
    endfunction

    function automatic result_t step_keyer(input logic [1:0] op, input logic [7:0] data);
        result_t r;
        logic    dit;
        logic    dah;
        logic    any;
        logic    after_dah;
        r = '0;
        dit = data[0];
        dah = data[1];
        any = dit || dah;
        if (data[2]) tick_pend = 1'b1;
        if (data[3]) dit_lat = 1'b1;
        if (data[4]) dah_lat = 1'b1;

        if (op == OP_ENABLE) begin
            r.tone_force_off = 1'b1;
            key_state = ST_IDLE;
        end else if (op == OP_DISABLE) begin
            r.tone_force_off = 1'b1;
            key_state = ST_DISABLED;
        end else if (op == OP_POLL) begin
            case (key_state)
                ST_IDLE: begin
                    if (key_mode == KEY_IAMBIC_A || key_mode == KEY_IAMBIC_B)
                        key_state = ST_IAM_IDLE;
                    else
                        key_state = ST_STR_IDLE;
                end
                ST_STR_IDLE: begin
                    if (any) begin
                        key_state = ST_STR_DOWN;
                        r.tone_start = 1'b1;
                    end
                end
                ST_STR_DOWN: begin
                    if (!any) begin
                        key_state = ST_IDLE;
                        r.tone_stop = 1'b1;
                    end
                end
                ST_IAM_IDLE: begin
                    if (tick_pend) begin
                        tick_pend = 1'b0;
                        if (unit_cnt != 8'hFF) unit_cnt = unit_cnt + 1'b1;
                    end
                    if (any) begin
                        key_state = dit ? ST_DIT : ST_DAH;
                        r.gap_valid = 1'b1;
                        r.gap_units = unit_cnt;
                        r.tone_start = 1'b1;
                        r.timer_restart = 1'b1;
                        tick_pend = 1'b0;
                        unit_cnt = '0;
                        elem_cnt = '0;
                    end
                end
                ST_DIT: begin
                    if (tick_pend) begin
                        tick_pend = 1'b0;
                        r.tone_stop = 1'b1;
                        r.symbol_valid = 1'b1;
                        key_state = ST_DIT_GAP;
                    end
                end
                ST_DAH: begin
                    if (tick_pend) begin
                        tick_pend = 1'b0;
                        if (unit_cnt != 8'hFF) unit_cnt = unit_cnt + 1'b1;
                        if (unit_cnt >= DAH_UNITS) begin
                            r.tone_stop = 1'b1;
                            r.symbol_valid = 1'b1;
                            r.symbol_is_dah = 1'b1;
                            key_state = ST_DAH_GAP;
                        end
                    end
                end
                ST_DIT_GAP, ST_DAH_GAP: begin
                    if (tick_pend) begin
                        after_dah = (key_state == ST_DAH_GAP);
                        tick_pend = 1'b0;
                        unit_cnt = '0;
                        if (elem_cnt != 8'hFF) elem_cnt = elem_cnt + 1'b1;
                        if (after_dah) dah_lat = 1'b0;
                        else dit_lat = 1'b0;
                        if (!any && key_mode == KEY_IAMBIC_A && elem_cnt >= MODE_A_ELEMENTS) begin
                            dit_lat = 1'b0;
                            dah_lat = 1'b0;
                            key_state = ST_IDLE;
                        end else if (after_dah && dit_lat) begin
                            key_state = ST_DIT;
                            r.tone_start = 1'b1;
                        end else if (dah_lat) begin
                            key_state = ST_DAH;
                            r.tone_start = 1'b1;
                        end else if (dit_lat) begin
                            key_state = ST_DIT;
                            r.tone_start = 1'b1;
                        end else begin
                            key_state = ST_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (r.tone_start) r.tone_value = tone_period;
        if (r.timer_restart) r.timer_value = unit_period;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_mode = KEY_STRAIGHT;
            tone_period = '0;
            unit_period = '0;
            key_state = ST_DISABLED;
            unit_cnt = '0;
            elem_cnt = '0;
            dit_lat = 1'b0;
            dah_lat = 1'b0;
            tick_pend = 1'b0;
            keyer_outputs.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_KEY_MODE:    key_mode = pwdata[1:0];
                    ADDR_TONE_PERIOD: tone_period = pwdata[TONE_W-1:0];
                    ADDR_UNIT_PERIOD: unit_period = pwdata[UNIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (keyer_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %s", describe(got));
                end else begin
                    want = keyer_outputs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch expected: %s", describe(want));
                            $display("         actual:   %s", describe(got));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                keyer_outputs.push_back(step_keyer(s_tuser, s_tdata));
        end
        outstanding = keyer_outputs.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import imk_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 160;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] KEY_UNUSED = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic [1:0]          s_tuser = OP_POLL;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int hold_left = 0;
    bit idle_en = 1'b1;
    logic dit_held = 1'b0;
    logic dah_held = 1'b0;

    always #6 aclk = ~aclk;

    iambic_morse_keyer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    keyer_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // hold off the result channel while hold_left runs down
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= !(idle_en && $urandom_range(99) < 30);
        end
    end

    function automatic logic [15:0] pick_period();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] op, input logic dit, input logic dah,
                             input logic tick, input logic dit_set, input logic dah_set);
        if (idle_en && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, dah_set, dit_set, tick, dah, dit};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [15:0] tone,
                             input logic [15:0] unit);
        drain();
        apb_write(ADDR_KEY_MODE, {30'd0, mode});
        apb_write(ADDR_TONE_PERIOD, {16'd0, tone});
        apb_write(ADDR_UNIT_PERIOD, {16'd0, unit});
    endtask

    // paddles held for stretches, press events on new presses plus noise
    task automatic random_run(input int count);
        int         r;
        logic [1:0] op;
        logic       was_dit;
        logic       was_dah;
        logic       dit_set;
        logic       dah_set;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            op = (r < 3) ? OP_ENABLE : (r < 5) ? OP_DISABLE : (r < 7) ? OP_UNUSED : OP_POLL;
            was_dit = dit_held;
            was_dah = dah_held;
            if ($urandom_range(99) < 12) dit_held = !dit_held;
            if ($urandom_range(99) < 12) dah_held = !dah_held;
            dit_set = (dit_held && !was_dit) || ($urandom_range(99) < 8);
            dah_set = (dah_held && !was_dah) || ($urandom_range(99) < 8);
            send_item(op, dit_held, dah_held, $urandom_range(99) < 45, dit_set, dah_set);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        configure(KEY_IAMBIC_B, 16'hFFFF, 16'h0000);
        send_item(OP_POLL, 1, 1, 1, 1, 1);
        send_item(OP_UNUSED, 0, 0, 0, 0, 0);
        send_item(OP_ENABLE, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 1, 1, 0, 0, 0);
        send_item(OP_POLL, 1, 1, 1, 0, 0);
        send_item(OP_POLL, 1, 1, 1, 0, 0);
        repeat (3) send_item(OP_POLL, 1, 1, 1, 0, 0);
        send_item(OP_POLL, 0, 0, 1, 0, 0);

        configure(KEY_IAMBIC_A, 16'h0000, 16'hFFFF);
        send_item(OP_ENABLE, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 1, 0, 0, 0, 1);
        send_item(OP_POLL, 1, 0, 1, 0, 0);
        send_item(OP_POLL, 0, 0, 1, 0, 0);
        repeat (3) send_item(OP_POLL, 0, 0, 1, 0, 0);
        send_item(OP_POLL, 0, 0, 1, 0, 0);

        configure(KEY_UNUSED, 16'h1234, 16'h5678);
        send_item(OP_ENABLE, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 0, 0, 0, 0, 0);
        send_item(OP_POLL, 0, 1, 1, 0, 0);
        send_item(OP_POLL, 0, 0, 0, 0, 0);
        send_item(OP_DISABLE, 1, 0, 0, 0, 0);
        send_item(OP_POLL, 1, 0, 0, 0, 0);

        // idle long enough to saturate the gap counter
        configure(KEY_IAMBIC_B, pick_period(), pick_period());
        send_item(OP_ENABLE, 0, 0, 0, 0, 0);
        repeat (270)
            send_item(OP_POLL, 0, 0, 1, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_item(OP_POLL, 1, 0, 0, 0, 0);

        for (int p = 0; p < 7; p++) begin
            idle_en = (p != 3);
            configure((p < 4) ? 2'(p) : 2'($urandom_range(3)), pick_period(), pick_period());
            if (p == 2) hold_left = HOLD_CYCLES;
            send_item(OP_ENABLE, 0, 0, 0, 0, 0);
            random_run(95);
        end

        drain();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/imk_pkg.sv
design/iambic_morse_keyer.sv
design/imk_checker.sv
test/keyer_checker.sv
test/tb.sv
